// ===== rtl/core/ich_pkg.sv =====
// shared constants, types and helpers of the intern table
package ich_pkg;

   // table geometry
   localparam int TABLE_SLOTS   = 4096;
   localparam int MAX_KEY_WORDS = 8;
   localparam int SLOT_BITS     = $clog2(TABLE_SLOTS);
   localparam int WIDX_BITS     = $clog2(MAX_KEY_WORDS);
   localparam int LEN_BITS      = $clog2(MAX_KEY_WORDS + 1);
   localparam int META_BITS     = LEN_BITS + 1;
   localparam int WADDR_BITS    = SLOT_BITS + WIDX_BITS;
   localparam int CNT_BITS      = $clog2(TABLE_SLOTS + 1);
   localparam int LOAD_LIMIT    = TABLE_SLOTS * 3 / 4;
   localparam int OUT_SLOT_BITS = 12;

   // hash primes
   localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
   localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
   localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
   localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
   localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_LONG = 2'd2
   } status_type;

   // hash sequencer
   typedef enum logic [3:0] {
      H_IDLE, H_WAIT, H_RND1, H_RND2, H_RND3, H_SUM1, H_SUM2, H_MERGE3,
      H_LEN, H_TAIL3, H_FIN1, H_FIN2, H_FIN3
   } hash_state_type;

   typedef enum logic [1:0] {
      PH_LANES, PH_MERGE, PH_TAIL
   } hash_phase_type;

   // table controller
   typedef enum logic [3:0] {
      T_CLEAR, T_COLLECT, T_HASH, T_META, T_CHECK, T_CMP_RD, T_CMP, T_STORE, T_EMIT
   } table_state_type;

   // rotate left by a fixed amount
   function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
      return (v << r) | (v >> (64 - r));
   endfunction

endpackage

// ===== rtl/core/ich_mul.sv =====
// iterative 64x64 multiplier, low 64 bits, one 32x32 product per cycle
module ich_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);

   logic [63:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] pa, pb;
   logic [63:0] pp;

   // partial product select: lo*lo, hi*lo, lo*hi
   always_comb begin
      pa = (step_ff == 2'd1) ? a_ff[63:32] : a_ff[31:0];
      pb = (step_ff == 2'd2) ? b_ff[63:32] : b_ff[31:0];
      pp = 64'(pa) * 64'(pb);
   end

   // step control and accumulation
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = (step_ff == 2'd0) ? pp : acc_ff + {pp[31:0], 32'd0};
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/core/ich_hash.sv =====
// xxh64 sequencer over the buffered key words, sharing one multiplier
module ich_hash (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ich_pkg::LEN_BITS-1:0]  key_len,
   output logic [ich_pkg::WIDX_BITS-1:0] word_idx,
   input  logic [63:0]                   word,
   output logic                          done,
   output logic [63:0]                   hash
);

   ich_pkg::hash_state_type state_ff, state_in, ret_ff, ret_in;
   ich_pkg::hash_phase_type phase_ff, phase_in;
   logic [1:0]                  k_ff, k_in;
   logic [ich_pkg::LEN_BITS-1:0] idx_ff, idx_in, n_ff, n_in;
   logic [63:0]                 lane_ff [4];
   logic [63:0]                 lane_in [4];
   logic [63:0]                 h_ff, h_in;
   logic                        done_ff, done_in;
   logic                        mul_start, mul_done;
   logic [63:0]                 mul_a, mul_b, mul_p, hx, acc_sel;

   ich_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .product(mul_p)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ich_pkg::H_IDLE: begin
            if (start) state_in = ich_pkg::H_RND1;
         end
         ich_pkg::H_WAIT: begin
            if (mul_done) state_in = ret_ff;
         end
         ich_pkg::H_RND1: begin
            state_in = ich_pkg::H_WAIT;
            ret_in   = ich_pkg::H_RND2;
         end
         ich_pkg::H_RND2: begin
            state_in = ich_pkg::H_WAIT;
            ret_in   = ich_pkg::H_RND3;
         end
         ich_pkg::H_RND3: begin
            case (phase_ff)
               ich_pkg::PH_LANES: begin
                  if (k_ff != 2'd3) state_in = ich_pkg::H_RND1;
                  else if (({1'b0, idx_ff} + 5'd5) <= {1'b0, n_ff})
                     state_in = ich_pkg::H_RND1;
                  else state_in = ich_pkg::H_SUM1;
               end
               ich_pkg::PH_MERGE: begin
                  state_in = ich_pkg::H_WAIT;
                  ret_in   = ich_pkg::H_MERGE3;
               end
               default: begin
                  state_in = ich_pkg::H_WAIT;
                  ret_in   = ich_pkg::H_TAIL3;
               end
            endcase
         end
         ich_pkg::H_SUM1: state_in = ich_pkg::H_SUM2;
         ich_pkg::H_SUM2: state_in = ich_pkg::H_RND1;
         ich_pkg::H_MERGE3: begin
            state_in = (k_ff == 2'd3) ? ich_pkg::H_LEN : ich_pkg::H_RND1;
         end
         ich_pkg::H_LEN: begin
            state_in = (idx_ff < n_ff) ? ich_pkg::H_RND1 : ich_pkg::H_FIN1;
         end
         ich_pkg::H_TAIL3: begin
            state_in = ((idx_ff + 1'b1) < n_ff) ? ich_pkg::H_RND1 : ich_pkg::H_FIN1;
         end
         ich_pkg::H_FIN1: begin
            state_in = ich_pkg::H_WAIT;
            ret_in   = ich_pkg::H_FIN2;
         end
         ich_pkg::H_FIN2: begin
            state_in = ich_pkg::H_WAIT;
            ret_in   = ich_pkg::H_FIN3;
         end
         ich_pkg::H_FIN3: state_in = ich_pkg::H_IDLE;
         default: state_in = ich_pkg::H_IDLE;
      endcase
   end

   // datapath and multiplier issue
   always_comb begin
      phase_in  = phase_ff;
      k_in      = k_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      h_in      = h_ff;
      lane_in   = lane_ff;
      done_in   = 1'b0;
      mul_start = 1'b0;
      mul_a     = 64'd0;
      mul_b     = 64'd0;
      hx        = h_ff ^ mul_p;
      acc_sel   = (phase_ff == ich_pkg::PH_LANES) ? lane_ff[k_ff] : 64'd0;
      case (state_ff)
         ich_pkg::H_IDLE: begin
            if (start) begin
               n_in   = key_len;
               idx_in = '0;
               k_in   = 2'd0;
               if (key_len >= ich_pkg::LEN_BITS'(4)) begin
                  phase_in   = ich_pkg::PH_LANES;
                  lane_in[0] = ich_pkg::PR1 + ich_pkg::PR2;
                  lane_in[1] = ich_pkg::PR2;
                  lane_in[2] = 64'd0;
                  lane_in[3] = 64'd0 - ich_pkg::PR1;
               end else begin
                  phase_in = ich_pkg::PH_TAIL;
                  h_in     = ich_pkg::PR5 + (64'(key_len) << 3);
               end
            end
         end
         ich_pkg::H_RND1: begin
            mul_start = 1'b1;
            mul_a     = (phase_ff == ich_pkg::PH_MERGE) ? lane_ff[k_ff] : word;
            mul_b     = ich_pkg::PR2;
         end
         ich_pkg::H_RND2: begin
            mul_start = 1'b1;
            mul_a     = ich_pkg::rotl64(acc_sel + mul_p, 31);
            mul_b     = ich_pkg::PR1;
         end
         ich_pkg::H_RND3: begin
            case (phase_ff)
               ich_pkg::PH_LANES: begin
                  lane_in[k_ff] = mul_p;
                  idx_in        = idx_ff + 1'b1;
                  k_in          = k_ff + 2'd1;
               end
               ich_pkg::PH_MERGE: begin
                  h_in      = hx;
                  mul_start = 1'b1;
                  mul_a     = hx;
                  mul_b     = ich_pkg::PR1;
               end
               default: begin
                  mul_start = 1'b1;
                  mul_a     = ich_pkg::rotl64(hx, 27);
                  mul_b     = ich_pkg::PR1;
               end
            endcase
         end
         ich_pkg::H_SUM1: begin
            h_in = ich_pkg::rotl64(lane_ff[0], 1) + ich_pkg::rotl64(lane_ff[1], 7);
         end
         ich_pkg::H_SUM2: begin
            h_in     = h_ff + ich_pkg::rotl64(lane_ff[2], 12) + ich_pkg::rotl64(lane_ff[3], 18);
            phase_in = ich_pkg::PH_MERGE;
            k_in     = 2'd0;
         end
         ich_pkg::H_MERGE3: begin
            h_in = mul_p + ich_pkg::PR4;
            k_in = k_ff + 2'd1;
         end
         ich_pkg::H_LEN: begin
            h_in     = h_ff + (64'(n_ff) << 3);
            phase_in = ich_pkg::PH_TAIL;
         end
         ich_pkg::H_TAIL3: begin
            h_in   = mul_p + ich_pkg::PR4;
            idx_in = idx_ff + 1'b1;
         end
         ich_pkg::H_FIN1: begin
            mul_start = 1'b1;
            mul_a     = h_ff ^ (h_ff >> 33);
            mul_b     = ich_pkg::PR2;
         end
         ich_pkg::H_FIN2: begin
            mul_start = 1'b1;
            mul_a     = mul_p ^ (mul_p >> 29);
            mul_b     = ich_pkg::PR3;
         end
         ich_pkg::H_FIN3: begin
            h_in    = mul_p ^ (mul_p >> 32);
            done_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ich_pkg::H_IDLE;
         ret_ff   <= ich_pkg::H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      k_ff     <= k_in;
      idx_ff   <= idx_in;
      n_ff     <= n_in;
      h_ff     <= h_in;
      lane_ff  <= lane_in;
   end

   assign word_idx = idx_ff[ich_pkg::WIDX_BITS-1:0];
   assign done     = done_ff;
   assign hash     = h_ff;

endmodule

// ===== rtl/core/hash_consing_intern_table.sv =====
// intern table top level: key buffer, slot memories and probe controller
//
//   channel | direction | tdata                       | tuser / tlast
//   req_    | in        | key_word[63:0]              | tlast = last_word
//   rsp_    | out       | slot_index[11:0], zero pad  | tuser = already_present, status
//
// Key words are taken one a cycle while a key is collected. At the last word
// the xxh64 sequencer waits on the shared multiplier for each 64-bit multiply:
// two per word of the four-lane stripes, three per remaining word, three per
// lane to merge the lanes of a key of four words or more and two for
// finalization. Each probe then reads the slot state and, if the lengths match,
// compares the stored words one by one; an insert writes one word a cycle.
// After reset a clearing pass empties all 4096 slot states before the first
// word is taken. Words are accepted while a result waits in the output
// register; a new result waits until that one is taken.
module hash_consing_intern_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key_word[63:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // slot_index[11:0], zero [15:12]
   output logic [2:0]  rsp_tuser    // already_present[0], status[2:1]
);

   ich_pkg::table_state_type     state_ff, state_in;
   logic [ich_pkg::SLOT_BITS-1:0] clr_ff, clr_in, slot_ff, slot_in, probe_ff, probe_in;
   logic [63:0]                  key_buf_ff [ich_pkg::MAX_KEY_WORDS];
   logic [ich_pkg::LEN_BITS-1:0] len_ff, len_in;
   logic                         long_ff, long_in;
   logic [ich_pkg::WIDX_BITS-1:0] widx_ff, widx_in;
   logic [ich_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [ich_pkg::SLOT_BITS-1:0] res_slot_ff, res_slot_in;
   logic                         res_present_ff, res_present_in;
   ich_pkg::status_type          res_status_ff, res_status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ich_pkg::OUT_SLOT_BITS-1:0] rsp_slot_ff, rsp_slot_in;
   logic                         rsp_present_ff, rsp_present_in;
   ich_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic [ich_pkg::META_BITS-1:0] meta_mem [ich_pkg::TABLE_SLOTS];
   logic [ich_pkg::META_BITS-1:0] meta_q, meta_wdata;
   logic [ich_pkg::SLOT_BITS-1:0] meta_waddr;
   logic                          meta_we;
   logic [63:0]                   word_mem [ich_pkg::TABLE_SLOTS * ich_pkg::MAX_KEY_WORDS];
   logic [63:0]                   word_q;
   logic [ich_pkg::WADDR_BITS-1:0] word_addr;
   logic                          word_we;

   logic                          accept, buf_we, too_long, emit_load, last_widx;
   logic                          hash_start, hash_done;
   logic [ich_pkg::WIDX_BITS-1:0] hash_widx;
   logic [63:0]                   hash_val;
   logic                          meta_used, len_match, word_match, wrap_out;

   ich_hash u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key_len (len_ff + 1'b1),
      .word_idx(hash_widx),
      .word    (key_buf_ff[hash_widx]),
      .done    (hash_done),
      .hash    (hash_val)
   );

   // handshake and probe conditions
   always_comb begin
      req_tready = (state_ff == ich_pkg::T_COLLECT);
      accept     = req_tvalid && req_tready;
      too_long   = long_ff || (len_ff == ich_pkg::LEN_BITS'(ich_pkg::MAX_KEY_WORDS));
      buf_we     = accept && !too_long;
      hash_start = accept && req_tlast && !too_long;
      emit_load  = (state_ff == ich_pkg::T_EMIT) && (!rsp_valid_ff || rsp_tready);
      meta_used  = meta_q[ich_pkg::LEN_BITS];
      len_match  = (meta_q[ich_pkg::LEN_BITS-1:0] == len_ff);
      word_match = (word_q == key_buf_ff[widx_ff]);
      last_widx  = (ich_pkg::LEN_BITS'(widx_ff) == (len_ff - 1'b1));
      wrap_out   = (probe_ff == ich_pkg::SLOT_BITS'(ich_pkg::TABLE_SLOTS - 1));
      word_addr  = {slot_ff, widx_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ich_pkg::T_CLEAR: begin
            if (clr_ff == ich_pkg::SLOT_BITS'(ich_pkg::TABLE_SLOTS - 1))
               state_in = ich_pkg::T_COLLECT;
         end
         ich_pkg::T_COLLECT: begin
            if (accept && req_tlast)
               state_in = too_long ? ich_pkg::T_EMIT : ich_pkg::T_HASH;
         end
         ich_pkg::T_HASH: begin
            if (hash_done) state_in = ich_pkg::T_META;
         end
         ich_pkg::T_META: state_in = ich_pkg::T_CHECK;
         ich_pkg::T_CHECK: begin
            if (!meta_used) begin
               state_in = (cnt_ff < ich_pkg::CNT_BITS'(ich_pkg::LOAD_LIMIT)) ?
                          ich_pkg::T_STORE : ich_pkg::T_EMIT;
            end else if (len_match) state_in = ich_pkg::T_CMP_RD;
            else state_in = wrap_out ? ich_pkg::T_EMIT : ich_pkg::T_META;
         end
         ich_pkg::T_CMP_RD: state_in = ich_pkg::T_CMP;
         ich_pkg::T_CMP: begin
            if (!word_match) state_in = wrap_out ? ich_pkg::T_EMIT : ich_pkg::T_META;
            else if (last_widx) state_in = ich_pkg::T_EMIT;
            else state_in = ich_pkg::T_CMP_RD;
         end
         ich_pkg::T_STORE: begin
            if (last_widx) state_in = ich_pkg::T_EMIT;
         end
         ich_pkg::T_EMIT: begin
            if (emit_load) state_in = ich_pkg::T_COLLECT;
         end
         default: state_in = ich_pkg::T_CLEAR;
      endcase
   end

   // register updates and memory writes
   always_comb begin
      clr_in         = clr_ff;
      slot_in        = slot_ff;
      probe_in       = probe_ff;
      len_in         = len_ff;
      long_in        = long_ff;
      widx_in        = widx_ff;
      cnt_in         = cnt_ff;
      res_slot_in    = res_slot_ff;
      res_present_in = res_present_ff;
      res_status_in  = res_status_ff;
      meta_we        = 1'b0;
      meta_waddr     = slot_ff;
      meta_wdata     = {1'b1, len_ff};
      word_we        = 1'b0;
      case (state_ff)
         ich_pkg::T_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            meta_wdata = '0;
            clr_in     = clr_ff + 1'b1;
         end
         ich_pkg::T_COLLECT: begin
            if (accept) begin
               if (too_long) long_in = 1'b1;
               else len_in = len_ff + 1'b1;
               res_slot_in    = '0;
               res_present_in = 1'b0;
               res_status_in  = ich_pkg::STATUS_LONG;
            end
         end
         ich_pkg::T_HASH: begin
            slot_in  = hash_val[ich_pkg::SLOT_BITS-1:0];
            probe_in = '0;
         end
         ich_pkg::T_CHECK: begin
            widx_in = '0;
            if (!meta_used) begin
               if (cnt_ff < ich_pkg::CNT_BITS'(ich_pkg::LOAD_LIMIT)) begin
                  meta_we = 1'b1;
                  cnt_in  = cnt_ff + 1'b1;
               end else begin
                  res_slot_in    = '0;
                  res_present_in = 1'b0;
                  res_status_in  = ich_pkg::STATUS_FULL;
               end
            end else if (!len_match) begin
               slot_in        = slot_ff + 1'b1;
               probe_in       = probe_ff + 1'b1;
               res_slot_in    = '0;
               res_present_in = 1'b0;
               res_status_in  = ich_pkg::STATUS_FULL;
            end
         end
         ich_pkg::T_CMP: begin
            if (!word_match) begin
               slot_in        = slot_ff + 1'b1;
               probe_in       = probe_ff + 1'b1;
               res_slot_in    = '0;
               res_present_in = 1'b0;
               res_status_in  = ich_pkg::STATUS_FULL;
            end else begin
               widx_in        = widx_ff + 1'b1;
               res_slot_in    = slot_ff;
               res_present_in = 1'b1;
               res_status_in  = ich_pkg::STATUS_OK;
            end
         end
         ich_pkg::T_STORE: begin
            word_we        = 1'b1;
            widx_in        = widx_ff + 1'b1;
            res_slot_in    = slot_ff;
            res_present_in = 1'b0;
            res_status_in  = ich_pkg::STATUS_OK;
         end
         ich_pkg::T_EMIT: begin
            if (emit_load) begin
               len_in  = '0;
               long_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_slot_in    = rsp_slot_ff;
      rsp_present_in = rsp_present_ff;
      rsp_status_in  = rsp_status_ff;
      if (emit_load) begin
         rsp_valid_in   = 1'b1;
         rsp_slot_in    = ich_pkg::OUT_SLOT_BITS'(res_slot_ff);
         rsp_present_in = res_present_ff;
         rsp_status_in  = res_status_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ich_pkg::T_CLEAR;
         clr_ff       <= '0;
         len_ff       <= '0;
         long_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         len_ff       <= len_in;
         long_ff      <= long_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      probe_ff       <= probe_in;
      widx_ff        <= widx_in;
      res_slot_ff    <= res_slot_in;
      res_present_ff <= res_present_in;
      res_status_ff  <= res_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_present_ff <= rsp_present_in;
      rsp_status_ff  <= rsp_status_in;
      if (buf_we) key_buf_ff[len_ff[ich_pkg::WIDX_BITS-1:0]] <= req_tdata;
   end

   // slot state memory: used flag and key length
   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
      meta_q <= meta_mem[slot_ff];
   end

   // key word memory
   always_ff @(posedge clock) begin
      if (word_we) word_mem[word_addr] <= key_buf_ff[widx_ff];
      word_q <= word_mem[word_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_slot_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_present_ff};

endmodule
